@@ sv/lsfe_pkg.sv @@
// lsfe_pkg: shared types and constants for the LSB stego frame extractor.
// Holds the parse phase encoding, result kind codes and register defaults.
// No dependencies.
package lsfe_pkg;

	// Parse phase, one-hot
	typedef enum logic [8:0] {
		PH_HEADER = 9'b0_0000_0001,
		PH_MLEN   = 9'b0_0000_0010,
		PH_MBYTE  = 9'b0_0000_0100,
		PH_ELEN   = 9'b0_0000_1000,
		PH_EBYTE  = 9'b0_0001_0000,
		PH_SLEN   = 9'b0_0010_0000,
		PH_SBYTE  = 9'b0_0100_0000,
		PH_DONE   = 9'b0_1000_0000,
		PH_ERR    = 9'b1_0000_0000
	} phase_t;

	// Result kind codes
	typedef enum logic [2:0] {
		KIND_MAGIC_LEN  = 3'd0,
		KIND_MAGIC_BYTE = 3'd1,
		KIND_EXT_LEN    = 3'd2,
		KIND_EXT_BYTE   = 3'd3,
		KIND_MSG_LEN    = 3'd4,
		KIND_MSG_BYTE   = 3'd5,
		KIND_MAGIC_ERR  = 3'd6,
		KIND_EXT_ERR    = 3'd7
	} kind_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_HEADER_BYTES  = 2'd0,
		REG_MAGIC_MAX_LEN = 2'd1,
		REG_EXT_MAX_LEN   = 2'd2
	} reg_idx_t;

	localparam int HDR_W  = 10;
	localparam int MAX_W  = 8;
	localparam int CFG_W  = 10;
	localparam int LEN_W  = 32;
	localparam int BCNT_W = 5;

	localparam logic [HDR_W-1:0] HEADER_BYTES_RST  = 10'd54;
	localparam logic [MAX_W-1:0] MAGIC_MAX_LEN_RST = 8'd20;
	localparam logic [MAX_W-1:0] EXT_MAX_LEN_RST   = 8'd5;

	// Bit position within a byte at which a byte completes
	localparam logic [BCNT_W-1:0] BYTE_LAST_BIT = 5'd7;

endpackage

@@ sv/lsb_stego_frame_extractor.sv @@
// lsb_stego_frame_extractor: skips an image header, collects pixel LSBs and
// parses the length/magic/extension/message frame into typed results.
// Depends on lsfe_pkg.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+------------------------------------------
//  s_*      | in  | s_tvalid/s_tready  | s_tuser = op, s_tdata = pixel_byte
//  m_*      | out | m_tvalid/m_tready  | m_tuser = kind, m_tdata = value, m_tlast
//  cfg_*    | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One image byte per cycle while the output register is not stalled: a request
// lands in the input register, is then parsed against the frame state and its
// result (if any) loads the output register. The output register is the only
// stall point: while a result waits, the input register still takes one more
// request. arst_n clears the parse state and restores register defaults.
module lsb_stego_frame_extractor (
	input  logic                       clk,
	input  logic                       arst_n,
	// input stream
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [7:0]                 s_tdata,    // [7:0] pixel_byte
	input  logic                       s_tuser,    // [0] op (1 = restart)
	// result stream
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [lsfe_pkg::LEN_W-1:0] m_tdata,    // [31:0] value
	output logic [2:0]                 m_tuser,    // [2:0] kind
	output logic                       m_tlast,    // last
	// configuration writes
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [1:0]                 cfg_index,
	input  logic [lsfe_pkg::CFG_W-1:0] cfg_data
);

	// configuration registers
	logic [lsfe_pkg::HDR_W-1:0] header_bytes_q;
	logic [lsfe_pkg::MAX_W-1:0] magic_max_q;
	logic [lsfe_pkg::MAX_W-1:0] ext_max_q;

	// input register
	logic valid_s1;
	logic op_s1;
	logic bit_s1;

	// frame state
	lsfe_pkg::phase_t                phase_q;
	logic [lsfe_pkg::HDR_W-1:0]      hdr_cnt_q;
	logic [lsfe_pkg::BCNT_W-1:0]     bit_cnt_q;
	logic [lsfe_pkg::LEN_W-1:0]      shift_q;
	logic [lsfe_pkg::LEN_W-1:0]      left_q;

	// output register
	logic                            out_valid_q;
	lsfe_pkg::kind_t                 kind_q;
	logic [lsfe_pkg::LEN_W-1:0]      value_q;
	logic                            last_q;

	// next-state logic
	lsfe_pkg::phase_t                phase_d;
	logic [lsfe_pkg::HDR_W-1:0]      hdr_cnt_d;
	logic [lsfe_pkg::BCNT_W-1:0]     bit_cnt_d;
	logic [lsfe_pkg::LEN_W-1:0]      shift_d;
	logic [lsfe_pkg::LEN_W-1:0]      left_d;
	logic                            emit;
	lsfe_pkg::kind_t                 kind_d;
	logic [lsfe_pkg::LEN_W-1:0]      value_d;
	logic                            last_d;

	logic                            advance;
	logic                            work;
	lsfe_pkg::phase_t                work_phase;
	logic [lsfe_pkg::LEN_W-1:0]      shift_in;
	logic [lsfe_pkg::BCNT_W-1:0]     bit_cnt_inc;
	logic [lsfe_pkg::LEN_W-1:0]      left_dec;

	// handshakes
	assign advance   = !out_valid_q || m_tready;
	assign s_tready  = !valid_s1 || advance;
	assign work      = valid_s1 && advance;
	assign cfg_ready = 1'b1;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = value_q;
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_bytes_q <= lsfe_pkg::HEADER_BYTES_RST;
			magic_max_q    <= lsfe_pkg::MAGIC_MAX_LEN_RST;
			ext_max_q      <= lsfe_pkg::EXT_MAX_LEN_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				lsfe_pkg::REG_HEADER_BYTES:  header_bytes_q <= cfg_data;
				lsfe_pkg::REG_MAGIC_MAX_LEN: magic_max_q <= cfg_data[lsfe_pkg::MAX_W-1:0];
				lsfe_pkg::REG_EXT_MAX_LEN:   ext_max_q <= cfg_data[lsfe_pkg::MAX_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1  <= s_tuser;
			bit_s1 <= s_tdata[0];
		end
	end

	// LSBs enter at the top, so a full word or a byte in [31:24] is LSB first
	assign shift_in    = {bit_s1, shift_q[lsfe_pkg::LEN_W-1:1]};
	assign bit_cnt_inc = bit_cnt_q + 1'b1;
	assign left_dec    = left_q - 1'b1;
	// header done: this byte already carries the first length bit
	assign work_phase  = (phase_q == lsfe_pkg::PH_HEADER) ? lsfe_pkg::PH_MLEN : phase_q;

	// frame parser
	always_comb begin
		phase_d   = phase_q;
		hdr_cnt_d = hdr_cnt_q;
		bit_cnt_d = bit_cnt_q;
		shift_d   = shift_q;
		left_d    = left_q;
		emit      = 1'b0;
		kind_d    = lsfe_pkg::KIND_MAGIC_LEN;
		value_d   = '0;
		last_d    = 1'b0;

		if (op_s1) begin
			phase_d   = lsfe_pkg::PH_HEADER;
			hdr_cnt_d = '0;
			bit_cnt_d = '0;
			shift_d   = '0;
			left_d    = '0;
		end else if (phase_q == lsfe_pkg::PH_HEADER && hdr_cnt_q < header_bytes_q) begin
			hdr_cnt_d = hdr_cnt_q + 1'b1;
		end else begin
			unique case (work_phase)
				lsfe_pkg::PH_MLEN, lsfe_pkg::PH_ELEN, lsfe_pkg::PH_SLEN: begin
					phase_d   = work_phase;
					shift_d   = shift_in;
					bit_cnt_d = bit_cnt_inc;
					if (bit_cnt_inc == '0) begin
						emit = 1'b1;
						if (work_phase == lsfe_pkg::PH_MLEN
						    && shift_in > {24'd0, magic_max_q}) begin
							phase_d = lsfe_pkg::PH_ERR;
							kind_d  = lsfe_pkg::KIND_MAGIC_ERR;
							last_d  = 1'b1;
						end else if (work_phase == lsfe_pkg::PH_ELEN
						             && shift_in > {24'd0, ext_max_q}) begin
							phase_d = lsfe_pkg::PH_ERR;
							kind_d  = lsfe_pkg::KIND_EXT_ERR;
							last_d  = 1'b1;
						end else begin
							value_d = shift_in;
							left_d  = shift_in;
							last_d  = (shift_in == '0);
							case (work_phase)
								lsfe_pkg::PH_MLEN: begin
									kind_d  = lsfe_pkg::KIND_MAGIC_LEN;
									phase_d = last_d ? lsfe_pkg::PH_ELEN : lsfe_pkg::PH_MBYTE;
								end
								lsfe_pkg::PH_ELEN: begin
									kind_d  = lsfe_pkg::KIND_EXT_LEN;
									phase_d = last_d ? lsfe_pkg::PH_SLEN : lsfe_pkg::PH_EBYTE;
								end
								default: begin
									kind_d  = lsfe_pkg::KIND_MSG_LEN;
									phase_d = last_d ? lsfe_pkg::PH_DONE : lsfe_pkg::PH_SBYTE;
								end
							endcase
						end
					end
				end
				lsfe_pkg::PH_MBYTE, lsfe_pkg::PH_EBYTE, lsfe_pkg::PH_SBYTE: begin
					shift_d   = shift_in;
					bit_cnt_d = bit_cnt_inc;
					if (bit_cnt_q == lsfe_pkg::BYTE_LAST_BIT) begin
						emit      = 1'b1;
						bit_cnt_d = '0;
						left_d    = left_dec;
						value_d   = {24'd0, shift_in[lsfe_pkg::LEN_W-1 -: 8]};
						last_d    = (left_dec == '0);
						case (work_phase)
							lsfe_pkg::PH_MBYTE: begin
								kind_d = lsfe_pkg::KIND_MAGIC_BYTE;
								if (last_d) phase_d = lsfe_pkg::PH_ELEN;
							end
							lsfe_pkg::PH_EBYTE: begin
								kind_d = lsfe_pkg::KIND_EXT_BYTE;
								if (last_d) phase_d = lsfe_pkg::PH_SLEN;
							end
							default: begin
								kind_d = lsfe_pkg::KIND_MSG_BYTE;
								if (last_d) phase_d = lsfe_pkg::PH_DONE;
							end
						endcase
					end
				end
				// done or error: bytes are dropped until a restart
				default: ;
			endcase
		end
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= lsfe_pkg::PH_HEADER;
			hdr_cnt_q <= '0;
			bit_cnt_q <= '0;
			shift_q   <= '0;
			left_q    <= '0;
		end else if (work) begin
			phase_q   <= phase_d;
			hdr_cnt_q <= hdr_cnt_d;
			bit_cnt_q <= bit_cnt_d;
			shift_q   <= shift_d;
			left_q    <= left_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (work && emit) begin
			kind_q  <= kind_d;
			value_q <= value_d;
			last_q  <= last_d;
		end
	end

	// checks
	a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (out_valid_q && !m_tready && valid_s1))
		else $error("input stalled without a blocked result");

	a_error_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(work && emit && (kind_d == lsfe_pkg::KIND_MAGIC_ERR
		                  || kind_d == lsfe_pkg::KIND_EXT_ERR))
		|=> (phase_q == lsfe_pkg::PH_ERR))
		else $error("length error did not stop the parser");

	a_header_no_bits: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == lsfe_pkg::PH_HEADER) |-> (bit_cnt_q == '0))
		else $error("bit count moved during header skip");

	a_error_has_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (kind_q == lsfe_pkg::KIND_MAGIC_ERR
		                 || kind_q == lsfe_pkg::KIND_EXT_ERR))
		|-> (last_q && value_q == '0))
		else $error("error result without last or with nonzero value");

endmodule
